FILE: design/apq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// apq_pkg
// Shared types and constants for the ascending priority queue cell chain.
// -----------------------------------------------------------------------------
package apq_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Command codes carried on the input channel
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic insert_en;
        logic shift_en;
    } ctrl_t;

    // Running minimum handed from cell to cell during a delete scan
    typedef struct packed {
        logic                     token;
        logic                     found;
        logic signed [DATA_W-1:0] min_value;
    } scan_t;

endpackage
`default_nettype wire

FILE: design/apq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// apq_cell
// One queue slot: holds an entry, takes appends and shift-downs, and folds its
// entry into the running minimum as the scan token passes through.
// -----------------------------------------------------------------------------
module apq_cell #(
    parameter int IDX_W      = 3,
    parameter int CNT_W      = 4,
    parameter int CELL_INDEX = 0
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire apq_pkg::ctrl_t                    ctrl,
    input  wire logic [CNT_W-1:0]                  fill,
    input  wire logic [IDX_W-1:0]                  best_idx,
    input  wire logic signed [apq_pkg::DATA_W-1:0] ins_value,
    input  wire logic signed [apq_pkg::DATA_W-1:0] next_value,
    output logic signed [apq_pkg::DATA_W-1:0]      value,
    input  wire apq_pkg::scan_t                    scan_in,
    input  wire logic [IDX_W-1:0]                  scan_idx_in,
    output apq_pkg::scan_t                         scan_out,
    output logic [IDX_W-1:0]                       scan_idx_out
);

    logic signed [apq_pkg::DATA_W-1:0] value_reg;
    logic signed [apq_pkg::DATA_W-1:0] value_next;
    apq_pkg::scan_t                    scan_reg;
    apq_pkg::scan_t                    scan_next;
    logic [IDX_W-1:0]                  scan_idx_reg;
    logic [IDX_W-1:0]                  scan_idx_next;
    logic                              occupied;
    logic                              take;

    assign occupied = CNT_W'(CELL_INDEX) < fill;

    // Strictly less keeps the earliest of equal minima
    assign take = occupied && (!scan_in.found || (value_reg < scan_in.min_value));

    always_comb begin
        value_next = value_reg;
        if (ctrl.insert_en && (fill == CNT_W'(CELL_INDEX))) begin
            value_next = ins_value;
        end else if (ctrl.shift_en && (IDX_W'(CELL_INDEX) >= best_idx)) begin
            value_next = next_value;
        end
    end

    always_comb begin
        scan_next     = scan_in;
        scan_idx_next = scan_idx_in;
        if (take) begin
            scan_next.found     = 1'b1;
            scan_next.min_value = value_reg;
            scan_idx_next       = IDX_W'(CELL_INDEX);
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        scan_idx_reg <= scan_idx_next;
        if (!aresetn) begin
            scan_reg <= '0;
        end else begin
            scan_reg <= scan_next;
        end
    end

    assign value        = value_reg;
    assign scan_out     = scan_reg;
    assign scan_idx_out = scan_idx_reg;

endmodule
`default_nettype wire

FILE: design/ascending_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ascending_priority_queue_top
// Bounded ascending priority queue built as a chain of entry cells.
// -----------------------------------------------------------------------------
// Each accepted item is either an insert, which appends a signed 32-bit value
// at the tail, or a delete, which removes the smallest stored value (the
// oldest one among equal values) and returns it; every item yields exactly one
// result item. An insert into a full queue returns overflow, a delete on an
// empty queue returns underflow, and both leave the queue untouched with a
// removed value of zero. Inserts, overflows and underflows are answered at the
// edge that accepts them, so they run at one item per cycle while the result
// register drains. A delete on a non-empty queue launches a scan token down
// the cell chain; the token advances one cell per cycle carrying the running
// minimum, and the result is registered as the token leaves the last cell;
// the queue accepts nothing in the meantime. The cycle the token leaves the
// last cell, every cell at or above the winning slot takes its upper
// neighbour's entry, closing the gap. There is no clearing pass after reset;
// the stored entries are not cleared.
// -----------------------------------------------------------------------------
module ascending_priority_queue_top #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_operation,
    input  wire logic signed [apq_pkg::DATA_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [apq_pkg::DATA_W-1:0]      m_removed_value,
    output logic [apq_pkg::STATUS_W-1:0]           m_status
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                            state_reg;
    logic [CNT_W-1:0]                  fill_reg;
    logic                              m_valid_reg;
    logic signed [apq_pkg::DATA_W-1:0] m_value_reg;
    apq_pkg::status_t                  m_status_reg;

    logic                              accept;
    logic                              is_full;
    logic                              is_empty;
    logic                              scan_done;
    apq_pkg::ctrl_t                    ctrl;

    apq_pkg::scan_t                    scan_chain [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]                  idx_chain  [QUEUE_DEPTH+1];
    logic signed [apq_pkg::DATA_W-1:0] cell_value [QUEUE_DEPTH];

    // Take a new item only while idle and the result register is free or
    // being emptied this cycle
    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign is_full  = fill_reg == CNT_W'(QUEUE_DEPTH);
    assign is_empty = fill_reg == '0;

    // Scan token leaving the last cell marks the end of a delete
    assign scan_done = scan_chain[QUEUE_DEPTH].token;

    assign ctrl.insert_en = accept && (s_operation == apq_pkg::OP_INSERT) && !is_full;
    assign ctrl.shift_en  = (state_reg == ST_SCAN) && scan_done;

    // Launch the token into cell zero with no minimum found yet
    assign scan_chain[0].token     = accept && (s_operation == apq_pkg::OP_DELETE) && !is_empty;
    assign scan_chain[0].found     = 1'b0;
    assign scan_chain[0].min_value = '0;
    assign idx_chain[0]            = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic signed [apq_pkg::DATA_W-1:0] upper_value;

        // The top cell refills from itself; its contents fall outside the fill
        if (i < QUEUE_DEPTH - 1) begin : g_mid
            assign upper_value = cell_value[i+1];
        end else begin : g_last
            assign upper_value = cell_value[i];
        end

        apq_cell #(
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .fill         (fill_reg),
            .best_idx     (idx_chain[QUEUE_DEPTH]),
            .ins_value    (s_value),
            .next_value   (upper_value),
            .value        (cell_value[i]),
            .scan_in      (scan_chain[i]),
            .scan_idx_in  (idx_chain[i]),
            .scan_out     (scan_chain[i+1]),
            .scan_idx_out (idx_chain[i+1])
        );
    end

    // Sequencer: fill count, state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
            m_value_reg  <= '0;
            m_status_reg <= apq_pkg::STATUS_DONE;
        end else begin
            // Drop the result once the consumer has taken it, unless a new
            // item is being accepted in the same cycle
            if (m_valid_reg && m_ready && !accept) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_operation == apq_pkg::OP_INSERT) begin
                            m_valid_reg <= 1'b1;
                            m_value_reg <= '0;
                            if (is_full) begin
                                m_status_reg <= apq_pkg::STATUS_OVERFLOW;
                            end else begin
                                m_status_reg <= apq_pkg::STATUS_DONE;
                                fill_reg     <= fill_reg + CNT_W'(1);
                            end
                        end else if (is_empty) begin
                            m_valid_reg  <= 1'b1;
                            m_value_reg  <= '0;
                            m_status_reg <= apq_pkg::STATUS_UNDERFLOW;
                        end else begin
                            // Hold off new items until the token leaves the last cell
                            m_valid_reg <= 1'b0;
                            state_reg   <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        state_reg    <= ST_IDLE;
                        fill_reg     <= fill_reg - CNT_W'(1);
                        m_valid_reg  <= 1'b1;
                        m_value_reg  <= scan_chain[QUEUE_DEPTH].min_value;
                        m_status_reg <= apq_pkg::STATUS_DONE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_removed_value = m_value_reg;
    assign m_status        = m_status_reg;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ascending priority queue.
// -----------------------------------------------------------------------------
// A queue of pending commands is filled up front: a short directed list covers
// the extreme values, an empty delete, a full insert, ties between equal minima
// and a full drain. Random traffic in bursts of insert-heavy, delete-heavy and
// balanced commands follows. A clocked driver offers the commands and a clocked
// monitor takes the results. At each accepted command a behavioural copy of
// the queue works out the answer. Each result is checked against the oldest
// answer still waiting. Both sides idle at random in the first two of three
// phases. The receiver is also held off for a long stretch so that the queue
// backs up; the sender also pauses once until every outstanding result drains.
// -----------------------------------------------------------------------------
module tb_top;
    import apq_pkg::*;

    localparam int QUEUE_DEPTH    = 8;
    localparam int RANDOM_CMDS    = 1000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 200000;

    // One command waiting to go into the queue, with its traffic controls
    typedef struct {
        logic                     op;
        logic signed [DATA_W-1:0] value;
        int                       phase;      // selects the idle rates
        bit                       hold_rx;    // start a long receiver hold-off
        bit                       drain_first; // wait for all results first
    } queue_cmd_t;

    // One answer from the queue
    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        status_t                  status;
    } queue_answer_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_operation = OP_INSERT;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_removed_value;
    logic [STATUS_W-1:0]      m_status;

    queue_cmd_t               pending_cmds [$];
    queue_answer_t            expected_answers [$];
    logic signed [DATA_W-1:0] held_values [$];   // predicted contents, oldest first

    int mismatches   = 0;
    int cycle_count  = 0;
    int current_phase = 0;
    int hold_rx_req  = 0;
    int holds_served = 0;
    int hold_left    = 0;
    int n_inserts    = 0;
    int n_removals   = 0;
    int n_overflows  = 0;
    int n_underflows = 0;
    int n_checked    = 0;

    ascending_priority_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_removed_value(m_removed_value),
        .m_status       (m_status)
    );

    always #10 aclk = ~aclk;

    // Apply one command to the predicted queue and return its answer
    function automatic queue_answer_t predict_queue_answer(logic op,
                                                           logic signed [DATA_W-1:0] value);
        queue_answer_t ans;
        int            best;
        ans.removed_value = '0;
        ans.status        = STATUS_DONE;
        if (op == OP_INSERT) begin
            if (held_values.size() >= QUEUE_DEPTH) begin
                ans.status = STATUS_OVERFLOW;
                n_overflows++;
            end else begin
                held_values.push_back(value);
                n_inserts++;
            end
        end else if (held_values.size() == 0) begin
            ans.status = STATUS_UNDERFLOW;
            n_underflows++;
        end else begin
            // strict compare keeps the earliest of equal minima
            best = 0;
            for (int i = 1; i < held_values.size(); i++) begin
                if (held_values[i] < held_values[best]) best = i;
            end
            ans.removed_value = held_values[best];
            held_values.delete(best);
            n_removals++;
        end
        return ans;
    endfunction

    function automatic int tx_idle_pct(int phase);
        case (phase)
            0:       return 33;
            1:       return 56;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(int phase);
        case (phase)
            0:       return 56;
            1:       return 33;
            default: return 0;
        endcase
    endfunction

    // Mix of narrow values (to force ties), corner values and full-width noise
    function automatic logic signed [DATA_W-1:0] random_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4) begin
            k = $urandom_range(0, 16);
            return k - 8;
        end
        if (k == 4) begin
            case ($urandom_range(0, 5))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return 32'sh7FFF_FFFE;
                3:       return 32'sh8000_0001;
                4:       return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic add_cmd(logic op, logic signed [DATA_W-1:0] value, int phase,
                           bit hold_rx = 0, bit drain_first = 0);
        queue_cmd_t c;
        c.op          = op;
        c.value       = value;
        c.phase       = phase;
        c.hold_rx     = hold_rx;
        c.drain_first = drain_first;
        pending_cmds.push_back(c);
    endtask

    // Driver: offer pending commands, hold each until it is accepted
    always @(posedge aclk) begin
        bit         accepted;
        queue_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            accepted = s_valid && s_ready;
            if (accepted) begin
                expected_answers.push_back(predict_queue_answer(s_operation, s_value));
            end
            // hold the payload steady while the item is refused
            if (!(s_valid && !accepted)) begin
                if (pending_cmds.size() > 0 &&
                    !(pending_cmds[0].drain_first && expected_answers.size() != 0) &&
                    $urandom_range(0, 99) >= tx_idle_pct(pending_cmds[0].phase)) begin
                    c = pending_cmds.pop_front();
                    s_valid       <= 1'b1;
                    s_operation   <= c.op;
                    s_value       <= c.value;
                    current_phase <= c.phase;
                    if (c.hold_rx) hold_rx_req <= hold_rx_req + 1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take results, check them, and throttle the result channel
    always @(posedge aclk) begin
        queue_answer_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result removed_value=%0d status=%0d",
                             $time, m_removed_value, m_status);
                end else begin
                    want = expected_answers.pop_front();
                    n_checked++;
                    if (m_removed_value !== want.removed_value) begin
                        mismatches++;
                        $display("%0t: removed_value expected %0d actual %0d",
                                 $time, want.removed_value, m_removed_value);
                    end
                    if (m_status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                    end
                end
            end
            // long hold-off on request, otherwise random idling by phase
            if (holds_served != hold_rx_req) begin
                holds_served = hold_rx_req;
                hold_left    = RX_HOLD_CYCLES;
                m_ready     <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct(current_phase));
            end
        end
    end

    // Watchdog on a cycle count
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, expected_answers.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int seg_left;
        int insert_pct;
        int phase;
        bit hold_rx;
        bit drain_first;
        logic op;

        // Directed: empty delete, fill with corners and ties, full inserts,
        // drain in order of priority, empty delete again, one round trip
        add_cmd(OP_DELETE, 32'shFFFF_FFFF, 0);
        add_cmd(OP_INSERT, 0, 0);
        add_cmd(OP_INSERT, -1, 0);
        add_cmd(OP_INSERT, 32'sh7FFF_FFFF, 0);
        add_cmd(OP_INSERT, 32'sh8000_0000, 0);
        add_cmd(OP_INSERT, 5, 0);
        add_cmd(OP_INSERT, -1, 0);
        add_cmd(OP_INSERT, 5, 0);
        add_cmd(OP_INSERT, 32'sh8000_0000, 0);
        add_cmd(OP_INSERT, 123, 0);
        add_cmd(OP_INSERT, 32'shAAAA_AAAA, 0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            add_cmd(OP_DELETE, (i % 2) ? 32'sh5555_5555 : 32'shAAAA_AAAA, 0);
        end
        add_cmd(OP_DELETE, 0, 0);
        add_cmd(OP_INSERT, 42, 0);
        add_cmd(OP_DELETE, 0, 0);

        // Random: bursts biased towards insert or delete so that the fill
        // level sweeps from empty to full and beyond
        seg_left   = 0;
        insert_pct = 50;
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(4, 20);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 20;
                    default: insert_pct = 50;
                endcase
            end
            seg_left--;
            phase       = (i * 3) / RANDOM_CMDS;
            hold_rx     = (i == 100);
            drain_first = (i == 500);
            // push inserts hard right after the hold-off starts
            if (i > 100 && i < 130) op = OP_INSERT;
            else op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
            add_cmd(op, random_value(), phase, hold_rx, drain_first);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || s_valid || expected_answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4 * QUEUE_DEPTH) @(posedge aclk);
        if (expected_answers.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, expected_answers.size());
        end

        $display("Checked %0d results: %0d inserts, %0d removals, %0d overflows, %0d underflows",
                 n_checked, n_inserts, n_removals, n_overflows, n_underflows);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
